[hw/rtl/lsbp_pkg.sv]
// ----------------------------------------------------------------------------
// LSB-first bit packer package
// Shared widths, constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package lsbp_pkg;

  localparam int unsigned CodeBits   = 32;
  localparam int unsigned LenBits    = 6;
  localparam int unsigned ByteBits   = 8;
  localparam int unsigned AccBits    = CodeBits + ByteBits;
  localparam int unsigned CntBits    = 6;
  localparam int unsigned MaxCodeLen = 32;
  localparam int unsigned InDataBits = 40;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_code;
    logic load_flush;
    logic shift;
    logic clear;
    logic final_byte;
  } lsbp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic more;
  } lsbp_status_t;

endpackage

[hw/rtl/lsbp_ctrl.sv]
// ----------------------------------------------------------------------------
// LSB-first bit packer controller
// Sequences loading of a code or flush item and the byte beats it releases.
// ----------------------------------------------------------------------------
module lsbp_ctrl import lsbp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         in_action_i,
  output logic         in_ready_o,
  input  logic         out_ready_i,
  output logic         out_valid_o,
  input  lsbp_status_t status_i,
  output lsbp_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StEmit,
    StFlush
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_action_i) begin
            cmd_o.load_flush = 1'b1;
            state_d          = StFlush;
          end else begin
            cmd_o.load_code = 1'b1;
            state_d         = StEmit;
          end
        end
      end
      StEmit: begin
        // a full byte only leaves once a further bit is behind it
        out_valid_o = status_i.more;
        if (!status_i.more) begin
          state_d = StIdle;
        end else if (out_ready_i) begin
          cmd_o.shift = 1'b1;
        end
      end
      StFlush: begin
        out_valid_o      = 1'b1;
        cmd_o.final_byte = 1'b1;
        if (out_ready_i) begin
          cmd_o.clear = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hw/rtl/lsbp_dp.sv]
// ----------------------------------------------------------------------------
// LSB-first bit packer datapath
// Bit accumulator with count; releases one byte per shift command.
// ----------------------------------------------------------------------------
module lsbp_dp import lsbp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [CodeBits-1:0] code_bits_i,
  input  logic [LenBits-1:0]  code_len_i,
  input  lsbp_cmd_t           cmd_i,
  output lsbp_status_t        status_o,
  output logic [ByteBits-1:0] out_byte_o,
  output logic                last_o
);

  logic [AccBits-1:0]  acc_q, acc_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic [LenBits-1:0]  len_clamped;
  logic [CodeBits-1:0] code_mask;
  logic [AccBits-1:0]  code_ext;
  logic [3:0]          flush_sh;
  logic [ByteBits-1:0] flush_byte;

  assign len_clamped = (code_len_i > LenBits'(MaxCodeLen)) ? LenBits'(MaxCodeLen) : code_len_i;
  assign code_mask   = (len_clamped == '0) ? '0
                     : ({CodeBits{1'b1}} >> (LenBits'(CodeBits) - len_clamped));
  assign code_ext    = {{ByteBits{1'b0}}, code_bits_i & code_mask} << cnt_q[3:0];

  // leftover bits move to the top of the final byte
  assign flush_sh    = 4'd8 - cnt_q[3:0];
  assign flush_byte  = (cnt_q == '0) ? '0 : (acc_q[ByteBits-1:0] << flush_sh);

  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    if (cmd_i.load_code) begin
      acc_d = acc_q | code_ext;
      cnt_d = cnt_q + len_clamped;
    end else if (cmd_i.load_flush) begin
      acc_d = {{CodeBits{1'b0}}, flush_byte};
      cnt_d = '0;
    end else if (cmd_i.shift) begin
      acc_d = acc_q >> ByteBits;
      cnt_d = cnt_q - CntBits'(ByteBits);
    end else if (cmd_i.clear) begin
      acc_d = '0;
      cnt_d = '0;
    end
  end

  assign status_o.more = (cnt_q > CntBits'(ByteBits));
  assign out_byte_o    = acc_q[ByteBits-1:0];
  assign last_o        = cmd_i.final_byte || (cnt_q <= CntBits'(2 * ByteBits));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

[hw/rtl/lsb_first_bit_packer_unit.sv]
// ----------------------------------------------------------------------------
// LSB-first bit packer
// Packs variable-length prefix codes into bytes, earliest bit in bit 0.
// ----------------------------------------------------------------------------
// Items are taken one at a time: a new item is not accepted until the last
// one's bytes are out. A code beat is loaded, then releases 0 to 4 bytes, each
// held for as long as the sink stalls, then closes; a flush beat is loaded and
// releases one byte, held for any stall on it. Bytes leave through the single
// byte lane out of the 40-bit accumulator. A full byte is held until a further
// bit arrives; tlast marks the final byte of each item.
module lsb_first_bit_packer_unit import lsbp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [InDataBits-1:0] s_axis_tdata,  // code_bits[31:0], code_len[37:32], zero pad
  input  logic                  s_axis_tuser,  // action (0 code, 1 flush)
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [ByteBits-1:0]   m_axis_tdata,  // out_byte[7:0]
  output logic                  m_axis_tlast
);

  lsbp_cmd_t    cmd;
  lsbp_status_t status;

  lsbp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lsbp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .code_bits_i (s_axis_tdata[CodeBits-1:0]),
    .code_len_i  (s_axis_tdata[CodeBits+LenBits-1:CodeBits]),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_byte_o  (m_axis_tdata),
    .last_o      (m_axis_tlast)
  );

endmodule

[verif/lsbp_tb_pkg.sv]
// ----------------------------------------------------------------------------
// LSB-first bit packer testbench package
// Beat kinds shared by stimulus and checker, and the checker's expected-byte record.
// ----------------------------------------------------------------------------
package lsbp_tb_pkg;

  timeunit 1ns;
  timeprecision 1ps;

  // tuser on the input stream
  typedef enum logic {
    ACT_CODE  = 1'b0,
    ACT_FLUSH = 1'b1
  } lsbp_action_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } packed_byte_t;

endpackage

[verif/lsbp_byte_checker.sv]
// ----------------------------------------------------------------------------
// LSB-first bit packer byte checker
// Watches both streams, predicts the packed bytes from the accepted input
// beats and compares each output beat with the oldest prediction.
// ----------------------------------------------------------------------------
module lsbp_byte_checker import lsbp_pkg::*; import lsbp_tb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [InDataBits-1:0] s_axis_tdata,  // code_bits[31:0], code_len[37:32], zero pad
  input  logic                  s_axis_tuser,  // action
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [ByteBits-1:0]   m_axis_tdata,  // out_byte[7:0]
  input  logic                  m_axis_tlast,
  output int                    err_count_o,
  output int                    pending_o,
  output int                    bytes_checked_o
);

  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]   acc_bits;
  logic [3:0]   acc_cnt;
  packed_byte_t byte_q[$];

  assign pending_o = byte_q.size();

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count_o++;
  endtask

  // Works out the bytes one input beat releases and queues them
  task automatic pack_beat(input lsbp_action_e act, input logic [CodeBits-1:0] code,
                           input logic [LenBits-1:0] len_in);
    logic [7:0]   outb[4];
    int unsigned  n;
    int unsigned  len;
    packed_byte_t nb;
    n   = 0;
    len = (len_in > 6'd32) ? 32 : len_in;
    if (act == ACT_FLUSH) begin
      if (acc_cnt >= 4'd8)
        outb[0] = acc_bits;
      else if (acc_cnt != 4'd0)
        outb[0] = acc_bits << (4'd8 - acc_cnt);
      else
        outb[0] = 8'h00;
      n        = 1;
      acc_bits = '0;
      acc_cnt  = '0;
    end else begin
      for (int i = 0; i < len; i++) begin
        // a full byte only leaves once the next bit turns up
        if (acc_cnt >= 4'd8) begin
          outb[n]  = acc_bits;
          n++;
          acc_bits = '0;
          acc_cnt  = '0;
        end
        acc_bits[acc_cnt[2:0]] = code[i];
        acc_cnt++;
      end
    end
    for (int k = 0; k < n; k++) begin
      nb.data = outb[k];
      nb.last = (k == n - 1);
      byte_q  = {byte_q, nb};
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    packed_byte_t exp_b;
    if (!rst_ni) begin
      acc_bits        <= '0;
      acc_cnt         <= '0;
      byte_q.delete();
      err_count_o     <= 0;
      bytes_checked_o <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        pack_beat(lsbp_action_e'(s_axis_tuser), s_axis_tdata[CodeBits-1:0],
                  s_axis_tdata[CodeBits +: LenBits]);
      if (m_axis_tvalid && m_axis_tready) begin
        if (byte_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat data=%02h last=%0b",
                                    m_axis_tdata, m_axis_tlast));
        end else begin
          exp_b = byte_q.pop_front();
          if (m_axis_tdata !== exp_b.data)
            report_mismatch($sformatf("data %02h, expected %02h", m_axis_tdata, exp_b.data));
          if (m_axis_tlast !== exp_b.last)
            report_mismatch($sformatf("last %0b, expected %0b (data %02h)",
                                      m_axis_tlast, exp_b.last, exp_b.data));
        end
        bytes_checked_o++;
      end
    end
  end

endmodule

[verif/lsb_first_bit_packer_unit_tb.sv]
// ----------------------------------------------------------------------------
// LSB-first bit packer testbench
// Directed corner beats then random prefix-code streams with flushes, with
// random gaps on the input and back-pressure on the output.
// ----------------------------------------------------------------------------
module lsb_first_bit_packer_unit_tb;

  import lsbp_pkg::*;
  import lsbp_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandBeats  = 270;
  localparam int QuietTail  = 40;
  localparam int DrainWait  = 20;
  localparam int CycleLimit = 200000;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [InDataBits-1:0] s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [ByteBits-1:0]   m_axis_tdata;
  logic                  m_axis_tlast;

  int err_count;
  int pending;
  int bytes_checked;
  int cycles;

  logic quiet   = 1'b0;
  logic gaps_on = 1'b1;
  int   n_codes, n_flushes, n_empty, n_long;

  lsb_first_bit_packer_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  lsbp_byte_checker chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tlast   (m_axis_tlast),
    .err_count_o    (err_count),
    .pending_o      (pending),
    .bytes_checked_o(bytes_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TIMEOUT after %0d cycles, %0d bytes still expected", cycles, pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Sink: random stall bursts, none once the tail starts
  initial begin
    @(posedge rst_ni);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  task automatic drive_beat(input lsbp_action_e act, input logic [CodeBits-1:0] code,
                            input logic [LenBits-1:0] len);
    if (!quiet && gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {2'b00, len, code};
    do @(posedge clk_i); while (!s_axis_tready);
    if (act == ACT_FLUSH)
      n_flushes++;
    else begin
      n_codes++;
      if (len == 0) n_empty++;
      if (len > 6'd32) n_long++;
    end
  endtask

  task automatic random_beat();
    int r;
    int unsigned len;
    r = $urandom_range(0, 99);
    if (r < 14) begin
      drive_beat(ACT_FLUSH, $urandom, LenBits'($urandom_range(0, 63)));
    end else begin
      r = $urandom_range(0, 99);
      if (r < 2)       len = $urandom_range(33, 63);
      else if (r < 6)  len = 0;
      else if (r < 75) len = $urandom_range(1, 12);
      else             len = $urandom_range(13, 32);
      drive_beat(ACT_CODE, $urandom, len[LenBits-1:0]);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners
    drive_beat(ACT_FLUSH, 32'h0, 6'd0);             // nothing pending
    drive_beat(ACT_CODE,  32'hFFFF_FFFF, 6'd0);     // empty code
    drive_beat(ACT_CODE,  32'hFFFF_FFFF, 6'd1);
    drive_beat(ACT_FLUSH, 32'h0, 6'd0);             // one bit lands in bit 7
    drive_beat(ACT_CODE,  32'h0000_00A5, 6'd8);
    drive_beat(ACT_FLUSH, 32'hFFFF_FFFF, 6'd63);    // full byte held, code fields ignored
    drive_beat(ACT_CODE,  32'hFFFF_FFFF, 6'd32);
    drive_beat(ACT_CODE,  32'h0000_0000, 6'd32);
    drive_beat(ACT_CODE,  32'hAAAA_AAAA, 6'd32);
    drive_beat(ACT_CODE,  32'hFFFF_FFE5, 6'd5);     // bits above the length ignored
    drive_beat(ACT_FLUSH, 32'h0, 6'd0);
    drive_beat(ACT_CODE,  32'h5555_5555, 6'd33);    // over-long, clamped
    drive_beat(ACT_CODE,  32'hCCCC_3333, 6'd63);
    drive_beat(ACT_CODE,  32'h0000_0F0F, 6'd7);
    drive_beat(ACT_CODE,  32'h0000_01F0, 6'd9);
    drive_beat(ACT_CODE,  32'h0000_33CC, 6'd16);
    drive_beat(ACT_CODE,  32'h0055_AA55, 6'd24);
    drive_beat(ACT_CODE,  32'h7FFF_FFFF, 6'd31);
    drive_beat(ACT_FLUSH, 32'h0, 6'd0);
    drive_beat(ACT_FLUSH, 32'h0, 6'd0);

    for (int i = 0; i < RandBeats; i++) begin
      if (i % 30 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      if (i == RandBeats - QuietTail) quiet = 1'b1;
      random_beat();
    end
    drive_beat(ACT_FLUSH, 32'h0, 6'd0);
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Sent %0d codes (%0d empty, %0d over-long) and %0d flushes;",
             n_codes, n_empty, n_long, n_flushes);
    $display("compared %0d packed bytes under random gaps and back-pressure", bytes_checked);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/lsbp_pkg.sv
hw/rtl/lsbp_ctrl.sv
hw/rtl/lsbp_dp.sv
hw/rtl/lsb_first_bit_packer_unit.sv
verif/lsbp_tb_pkg.sv
verif/lsbp_byte_checker.sv
verif/lsb_first_bit_packer_unit_tb.sv
